>>> src/rhc_pkg.sv
// shared types, constants and tables for the rgb565 / hsv converter
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int CH_W    = 8;
    localparam int COLOR_W = 16;

    localparam int CH5_MAX = 31;
    localparam int CH6_MAX = 63;
    localparam int CH8_MAX = 255;

    localparam int HUE_STEP  = 43;
    localparam int HUE_OFF_G = 85;
    localparam int HUE_OFF_B = 171;
    localparam int REM_SCALE = 6;

    // divider geometry
    localparam int DIV_STG = 4;
    localparam int HUE_NW  = 14;
    localparam int HUE_QW  = 6;
    localparam int SAT_NW  = 16;
    localparam int SAT_QW  = 8;

    // pipeline depth: expand, prepare, divide, finish
    localparam int NSTG    = DIV_STG + 3;
    localparam int REV_STG = 4;

    localparam logic ACT_FWD = 1'b0;
    localparam logic ACT_REV = 1'b1;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GRN,
        MAX_BLU
    } max_ch_t;

    typedef enum logic [2:0] {
        HR_RED_YEL,
        HR_YEL_GRN,
        HR_GRN_CYN,
        HR_CYN_BLU,
        HR_BLU_MAG,
        HR_MAG_RED
    } hue_rgn_t;

    typedef struct packed {
        logic                action;
        logic [COLOR_W-1:0]  color_in;
        logic [CH_W-1:0]     hue_in;
        logic [CH_W-1:0]     sat_in;
        logic [CH_W-1:0]     val_in;
    } rhc_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0]  color_out;
        logic [CH_W-1:0]     hue_out;
        logic [CH_W-1:0]     sat_out;
        logic [CH_W-1:0]     val_out;
    } rhc_out_t;

    // per-item control that rides along the forward dividers
    typedef struct packed {
        logic            act;
        logic [CH_W-1:0] mx;
        logic            grey;
        logic            black;
        logic            neg;
        logic [CH_W-1:0] off;
    } fwd_side_t;

    typedef logic [CH_W-1:0] exp5_tbl_t [32];
    typedef logic [CH_W-1:0] exp6_tbl_t [64];

    function automatic exp5_tbl_t build_exp5();
        exp5_tbl_t t;
        for (int i = 0; i < 32; i++)
        begin
            t[i] = CH_W'((i * CH8_MAX) / CH5_MAX);
        end
        return t;
    endfunction

    function automatic exp6_tbl_t build_exp6();
        exp6_tbl_t t;
        for (int i = 0; i < 64; i++)
        begin
            t[i] = CH_W'((i * CH8_MAX) / CH6_MAX);
        end
        return t;
    endfunction

    localparam exp5_tbl_t EXP5_TBL = build_exp5();
    localparam exp6_tbl_t EXP6_TBL = build_exp6();

    function automatic logic [CH_W-1:0] rgn_base(input hue_rgn_t rgn);
        logic [CH_W-1:0] b;
        case (rgn)
            HR_RED_YEL: b = '0;
            HR_YEL_GRN: b = CH_W'(HUE_STEP);
            HR_GRN_CYN: b = CH_W'(HUE_STEP * 2);
            HR_CYN_BLU: b = CH_W'(HUE_STEP * 3);
            HR_BLU_MAG: b = CH_W'(HUE_STEP * 4);
            HR_MAG_RED: b = CH_W'(HUE_STEP * 5);
            default:    b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [COLOR_W-1:0] pack565(
        input logic [CH_W-1:0] r,
        input logic [CH_W-1:0] g,
        input logic [CH_W-1:0] b
    );
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

>>> src/rhc_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface rhc_in_if;
    logic             valid;
    logic             ready;
    rhc_pkg::rhc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rhc_out_if;
    logic              valid;
    logic              ready;
    rhc_pkg::rhc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/rhc_div.sv
// pipelined restoring divider, a few quotient bits per stage
`timescale 1ns / 1ps

module rhc_div #(
    parameter int NW  = rhc_pkg::SAT_NW,
    parameter int QW  = rhc_pkg::SAT_QW,
    parameter int STG = rhc_pkg::DIV_STG,
    parameter int DW  = rhc_pkg::CH_W
) (
    input  logic           clk,
    input  logic [STG-1:0] en,
    input  logic [NW-1:0]  num,
    input  logic [DW-1:0]  den,
    output logic [QW-1:0]  quo
);

    localparam int BPS = (QW + STG - 1) / STG;
    localparam int CW  = NW + DW;

    logic [NW-1:0] rem_reg [STG];
    logic [DW-1:0] den_reg [STG];
    logic [QW-1:0] quo_reg [STG];

    genvar s;
    generate
        for (s = 0; s < STG; s++)
        begin : g_stage
            logic [NW-1:0] rem_src;
            logic [NW-1:0] rem_next;
            logic [DW-1:0] den_src;
            logic [QW-1:0] quo_src;
            logic [QW-1:0] quo_next;

            if (s == 0)
            begin : g_first
                assign rem_src = num;
                assign den_src = den;
                assign quo_src = '0;
            end
            else
            begin : g_rest
                assign rem_src = rem_reg[s-1];
                assign den_src = den_reg[s-1];
                assign quo_src = quo_reg[s-1];
            end

            always_comb
            begin
                logic [CW-1:0] sh;
                logic          ge;
                sh       = '0;
                ge       = 1'b0;
                rem_next = rem_src;
                quo_next = quo_src;
                for (int j = 0; j < BPS; j++)
                begin
                    if (s * BPS + j < QW)
                    begin
                        sh = CW'(den_src) << (QW - 1 - s * BPS - j);
                        ge = CW'(rem_next) >= sh;
                        if (ge)
                        begin
                            rem_next = rem_next - NW'(sh);
                        end
                        quo_next = {quo_next[QW-2:0], ge};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_src;
                    quo_reg[s] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[STG-1];

endmodule

>>> src/rhc_fwd.sv
// forward path: rgb565 to hue, saturation and value
`timescale 1ns / 1ps

module rhc_fwd (
    input  logic                          clk,
    input  logic [rhc_pkg::NSTG-1:0]      en,
    input  logic                          action,
    input  logic [rhc_pkg::COLOR_W-1:0]   color_in,
    output logic [rhc_pkg::CH_W-1:0]      hue_out,
    output logic [rhc_pkg::CH_W-1:0]      sat_out,
    output logic [rhc_pkg::CH_W-1:0]      val_out
);

    import rhc_pkg::*;

    // stage 0: channel expansion and max / min
    logic [CH_W-1:0] r_next, g_next, b_next, mx_next, mn_next;
    max_ch_t         sel_next;
    logic            act0_reg;
    logic [CH_W-1:0] r0_reg, g0_reg, b0_reg, mx0_reg, mn0_reg;
    max_ch_t         sel0_reg;

    always_comb
    begin
        r_next = EXP5_TBL[color_in[15:11]];
        g_next = EXP6_TBL[color_in[10:5]];
        b_next = EXP5_TBL[color_in[4:0]];
        // red wins ties, then green
        if (r_next >= g_next && r_next >= b_next)
        begin
            sel_next = MAX_RED;
            mx_next  = r_next;
        end
        else if (g_next >= b_next)
        begin
            sel_next = MAX_GRN;
            mx_next  = g_next;
        end
        else
        begin
            sel_next = MAX_BLU;
            mx_next  = b_next;
        end
        mn_next = r_next;
        if (g_next < mn_next)
        begin
            mn_next = g_next;
        end
        if (b_next < mn_next)
        begin
            mn_next = b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            act0_reg <= action;
            r0_reg   <= r_next;
            g0_reg   <= g_next;
            b0_reg   <= b_next;
            mx0_reg  <= mx_next;
            mn0_reg  <= mn_next;
            sel0_reg <= sel_next;
        end
    end

    // stage 1: sector numerator and dividends
    logic [CH_W-1:0]   d_next, a_sel, b_sel, mag_next;
    fwd_side_t         side_next;
    logic [HUE_NW-1:0] hnum_next;
    logic [SAT_NW-1:0] snum_next;
    fwd_side_t         side1_reg;
    logic [CH_W-1:0]   d1_reg;
    logic [HUE_NW-1:0] hnum1_reg;
    logic [SAT_NW-1:0] snum1_reg;

    always_comb
    begin
        d_next = mx0_reg - mn0_reg;
        case (sel0_reg)
            MAX_RED:
            begin
                a_sel         = g0_reg;
                b_sel         = b0_reg;
                side_next.off = '0;
            end
            MAX_GRN:
            begin
                a_sel         = b0_reg;
                b_sel         = r0_reg;
                side_next.off = CH_W'(HUE_OFF_G);
            end
            MAX_BLU:
            begin
                a_sel         = r0_reg;
                b_sel         = g0_reg;
                side_next.off = CH_W'(HUE_OFF_B);
            end
            default:
            begin
                a_sel         = g0_reg;
                b_sel         = b0_reg;
                side_next.off = '0;
            end
        endcase
        side_next.act   = act0_reg;
        side_next.mx    = mx0_reg;
        side_next.grey  = (d_next == '0);
        side_next.black = (mx0_reg == '0);
        side_next.neg   = (a_sel < b_sel);
        mag_next        = side_next.neg ? (b_sel - a_sel) : (a_sel - b_sel);
        hnum_next       = HUE_NW'(mag_next) * HUE_NW'(HUE_STEP);
        snum_next       = {d_next, 8'h00} - SAT_NW'(d_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side1_reg <= side_next;
            d1_reg    <= d_next;
            hnum1_reg <= hnum_next;
            snum1_reg <= snum_next;
        end
    end

    // stages 2 .. DIV_STG+1: dividers with control riding alongside
    logic [HUE_QW-1:0] hq;
    logic [SAT_QW-1:0] sq;
    fwd_side_t         side_dly_reg [DIV_STG];

    rhc_div #(
        .NW  (HUE_NW),
        .QW  (HUE_QW),
        .STG (DIV_STG),
        .DW  (CH_W)
    ) u_hue_div (
        .clk (clk),
        .en  (en[DIV_STG+1:2]),
        .num (hnum1_reg),
        .den (d1_reg),
        .quo (hq)
    );

    rhc_div #(
        .NW  (SAT_NW),
        .QW  (SAT_QW),
        .STG (DIV_STG),
        .DW  (CH_W)
    ) u_sat_div (
        .clk (clk),
        .en  (en[DIV_STG+1:2]),
        .num (snum1_reg),
        .den (side1_reg.mx),
        .quo (sq)
    );

    genvar s;
    generate
        for (s = 0; s < DIV_STG; s++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en[s+2])
                begin
                    if (s == 0)
                    begin
                        side_dly_reg[s] <= side1_reg;
                    end
                    else
                    begin
                        side_dly_reg[s] <= side_dly_reg[(s == 0) ? 0 : s-1];
                    end
                end
            end
        end
    endgenerate

    // last stage: signed sector step plus offset, wrapped to 8 bits; all outputs zero for reverse requests
    fwd_side_t       side_f;
    logic [CH_W-1:0] hq8, hue_next, sat_next, val_next;
    logic [CH_W-1:0] hue_reg, sat_reg, val_reg;

    always_comb
    begin
        side_f   = side_dly_reg[DIV_STG-1];
        hq8      = CH_W'(hq);
        hue_next = side_f.grey ? '0
                 : side_f.off + (side_f.neg ? (CH_W'(0) - hq8) : hq8);
        sat_next = side_f.black ? '0 : sq;
        val_next = side_f.mx;
        if (side_f.act == ACT_REV)
        begin
            hue_next = '0;
            sat_next = '0;
            val_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign hue_out = hue_reg;
    assign sat_out = sat_reg;
    assign val_out = val_reg;

endmodule

>>> src/rhc_rev.sv
// reverse path: hue, saturation and value to rgb565
`timescale 1ns / 1ps

module rhc_rev (
    input  logic                          clk,
    input  logic [rhc_pkg::NSTG-1:0]      en,
    input  logic                          action,
    input  logic [rhc_pkg::CH_W-1:0]      hue_in,
    input  logic [rhc_pkg::CH_W-1:0]      sat_in,
    input  logic [rhc_pkg::CH_W-1:0]      val_in,
    output logic [rhc_pkg::COLOR_W-1:0]   color_out
);

    import rhc_pkg::*;

    localparam int DLY = NSTG - REV_STG;
    localparam int PW  = 2 * CH_W;

    // stage 0: hue region, remainder and p
    hue_rgn_t          rgn_next;
    logic [CH_W-1:0]   diff, rem_next;
    logic [2*CH_W-1:0] p_prod;
    logic              act0_reg;
    hue_rgn_t          rgn0_reg;
    logic [CH_W-1:0]   rem0_reg, v0_reg, s0_reg, p0_reg;

    always_comb
    begin
        if (hue_in >= CH_W'(HUE_STEP * 5))
        begin
            rgn_next = HR_MAG_RED;
        end
        else if (hue_in >= CH_W'(HUE_STEP * 4))
        begin
            rgn_next = HR_BLU_MAG;
        end
        else if (hue_in >= CH_W'(HUE_STEP * 3))
        begin
            rgn_next = HR_CYN_BLU;
        end
        else if (hue_in >= CH_W'(HUE_STEP * 2))
        begin
            rgn_next = HR_GRN_CYN;
        end
        else if (hue_in >= CH_W'(HUE_STEP))
        begin
            rgn_next = HR_YEL_GRN;
        end
        else
        begin
            rgn_next = HR_RED_YEL;
        end
        diff     = hue_in - rgn_base(rgn_next);
        rem_next = diff * CH_W'(REM_SCALE);
        p_prod   = PW'(val_in) * PW'(CH_W'(CH8_MAX) - sat_in);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            act0_reg <= action;
            rgn0_reg <= rgn_next;
            rem0_reg <= rem_next;
            v0_reg   <= val_in;
            s0_reg   <= sat_in;
            p0_reg   <= p_prod[15:8];
        end
    end

    // stage 1: scaled saturation terms
    logic [2*CH_W-1:0] sr_prod, st_prod;
    logic              act1_reg;
    hue_rgn_t          rgn1_reg;
    logic [CH_W-1:0]   v1_reg, p1_reg, sr1_reg, st1_reg;

    always_comb
    begin
        sr_prod = PW'(s0_reg) * PW'(rem0_reg);
        st_prod = PW'(s0_reg) * PW'(CH_W'(CH8_MAX) - rem0_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            act1_reg <= act0_reg;
            rgn1_reg <= rgn0_reg;
            v1_reg   <= v0_reg;
            p1_reg   <= p0_reg;
            sr1_reg  <= sr_prod[15:8];
            st1_reg  <= st_prod[15:8];
        end
    end

    // stage 2: q and t
    logic [2*CH_W-1:0] q_prod, t_prod;
    logic              act2_reg;
    hue_rgn_t          rgn2_reg;
    logic [CH_W-1:0]   v2_reg, p2_reg, q2_reg, t2_reg;

    always_comb
    begin
        q_prod = PW'(v1_reg) * PW'(CH_W'(CH8_MAX) - sr1_reg);
        t_prod = PW'(v1_reg) * PW'(CH_W'(CH8_MAX) - st1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            act2_reg <= act1_reg;
            rgn2_reg <= rgn1_reg;
            v2_reg   <= v1_reg;
            p2_reg   <= p1_reg;
            q2_reg   <= q_prod[15:8];
            t2_reg   <= t_prod[15:8];
        end
    end

    // stage 3: region select and pack
    logic [COLOR_W-1:0] color_next;
    logic [COLOR_W-1:0] color3_reg;

    always_comb
    begin
        case (rgn2_reg)
            HR_RED_YEL: color_next = pack565(v2_reg, t2_reg, p2_reg);
            HR_YEL_GRN: color_next = pack565(q2_reg, v2_reg, p2_reg);
            HR_GRN_CYN: color_next = pack565(p2_reg, v2_reg, t2_reg);
            HR_CYN_BLU: color_next = pack565(p2_reg, q2_reg, v2_reg);
            HR_BLU_MAG: color_next = pack565(t2_reg, p2_reg, v2_reg);
            default:    color_next = pack565(v2_reg, p2_reg, q2_reg);
        endcase
        if (act2_reg == ACT_FWD)
        begin
            color_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            color3_reg <= color_next;
        end
    end

    // delay to match the forward path depth
    logic [COLOR_W-1:0] color_dly_reg [DLY];

    genvar s;
    generate
        for (s = 0; s < DLY; s++)
        begin : g_dly
            if (s == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en[REV_STG])
                    begin
                        color_dly_reg[s] <= color3_reg;
                    end
                end
            end
            else
            begin : g_rest
                always_ff @(posedge clk)
                begin
                    if (en[REV_STG+s])
                    begin
                        color_dly_reg[s] <= color_dly_reg[s-1];
                    end
                end
            end
        end
    endgenerate

    assign color_out = color_dly_reg[DLY-1];

endmodule

>>> src/rgb565_hsv_converter_top.sv
// 7 register stages from request accept to result valid
// throughput: one request per cycle while result.ready is high; the depth is set by the 4-stage dividers
// of the forward path (2 quotient bits per stage) plus expand, prepare and finish stages
// each full stage holds while the one after it is full and stalled, so bubbles close up
// reset clears the stage valid bits only; payload registers are not reset
`timescale 1ns / 1ps

module rgb565_hsv_converter_top (
    input  logic      clk,
    input  logic      rst_n,
    rhc_in_if.sink    pixel,
    rhc_out_if.source result
);

    import rhc_pkg::*;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] vld_shift;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || result.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_shift = {vld_reg[NSTG-2:0], pixel.valid};
        vld_next  = (en & vld_shift) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    rhc_fwd u_fwd (
        .clk      (clk),
        .en       (en),
        .action   (pixel.data.action),
        .color_in (pixel.data.color_in),
        .hue_out  (result.data.hue_out),
        .sat_out  (result.data.sat_out),
        .val_out  (result.data.val_out)
    );

    rhc_rev u_rev (
        .clk       (clk),
        .en        (en),
        .action    (pixel.data.action),
        .hue_in    (pixel.data.hue_in),
        .sat_in    (pixel.data.sat_in),
        .val_in    (pixel.data.val_in),
        .color_out (result.data.color_out)
    );

    assign pixel.ready  = en[0];
    assign result.valid = vld_reg[NSTG-1];

    // full pipe with a stalled result must push back on requests
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !result.ready |-> !pixel.ready)
        else $error("request taken while pipeline full and stalled");

    // one of the two result groups is always zero
    a_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.color_out == '0) ||
            (result.data.hue_out == '0 && result.data.sat_out == '0 &&
             result.data.val_out == '0))
        else $error("both forward and reverse fields nonzero");

    // nonzero saturation needs a nonzero value
    a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.sat_out != '0 |-> result.data.val_out != '0)
        else $error("saturation without value");

    // a colored hue means the channels differ, so saturation is nonzero
    a_hue_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.hue_out != '0 |-> result.data.sat_out != '0)
        else $error("hue without saturation");

endmodule
